>>> hdl/cbs_pkg.sv
// shared constants and types for the cardinal b-spline evaluator
package cbs_pkg;

  // fixed field widths of the channels and the order register
  localparam int unsigned POS_W      = 21;
  localparam int unsigned OUT_W      = 17;
  localparam int unsigned ORDER_W    = 4;

  // order value after reset and the order of the tent level
  localparam logic [ORDER_W-1:0] ORDER_RST = 4'd4;
  localparam int unsigned         TENT_ORDER = 2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TENT,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_FINISH
  } cbs_state_e;

endpackage

>>> hdl/cbs_pos_if.sv
// channel that carries one evaluation position per transfer
interface cbs_pos_if import cbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

>>> hdl/cbs_val_if.sv
// channel that carries one spline value per transfer
interface cbs_val_if import cbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] spline_value;

  modport source (output valid, output spline_value, input ready);
  modport sink   (input valid, input spline_value, output ready);
endinterface

>>> hdl/cardinal_bspline_eval.sv
// cardinal b-spline evaluator: triangle of cox-de boor levels on one shared multiplier
//
//   channel   dir  handshake          payload
//   pos_i     in   valid / ready      position      (signed, FRAC_BITS fraction bits)
//   val_o     out  valid / ready      spline_value  (unsigned, FRAC_BITS fraction bits)
//   cfg       in   cfg_we_i           cfg_wdata_i   (spline order, takes effect next item)
//
// per item for order n >= 2: one S_TENT step per tent entry, then S_MUL_LO, S_MUL_HI and S_DIV
//   for each entry of the higher levels; an entry outside its support leaves S_MUL_LO as a zero
// this sequence is set by the single multiplier: two products and one reciprocal product per entry
// orders below two go from S_IDLE straight to S_FINISH
// reset is asynchronous, active low; it clears the sequencer, output valid and sets order to 4
// pos_i is ready only between items; a finished value waits in the output register while the
// next position is taken, and the sequencer holds in its last state if that register is full
module cardinal_bspline_eval import cbs_pkg::*; #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ORDER_W-1:0] cfg_wdata_i,
  cbs_pos_if.sink            pos_i,
  cbs_val_if.source          val_o
);

  // widths derived from the parameters
  localparam int unsigned NW = $clog2(MAX_ORDER + 1);                  // order and counters
  localparam int unsigned IW = $clog2(MAX_ORDER);                      // level slot index
  localparam int unsigned L  = MAX_ORDER;                              // level slots
  localparam int unsigned LW = FRAC_BITS + 1;                          // level value, q1.f
  localparam int unsigned KW = $clog2((MAX_ORDER << FRAC_BITS) + 1);   // 0 .. k*one
  localparam int unsigned DL = $clog2(MAX_ORDER);                      // divisor bits
  localparam int unsigned RW = KW + DL;                                // reciprocal, and its shift
  localparam int unsigned PW = KW + RW;                                // product
  localparam int unsigned AW = KW + FRAC_BITS + 1;                     // accumulator
  localparam int unsigned SW = ((KW > POS_W) ? KW : POS_W) + 2;        // signed arguments

  localparam logic signed [SW-1:0] ONE_S = SW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] TENT_S = SW'(64'(TENT_ORDER) << FRAC_BITS);

  // reciprocal table: floor(m / d) == (m * recip[d]) >> RW for m below 2^KW and d from 2 to MAX_ORDER - 1
  logic [RW-1:0] recip_w [MAX_ORDER];

  assign recip_w[0] = '0;
  assign recip_w[1] = '0;
  for (genvar g = 2; g < MAX_ORDER; g++) begin : g_recip
    localparam logic [63:0] RV = ((64'd1 << RW) + 64'(g) - 64'd1) / 64'(g);
    assign recip_w[g] = RW'(RV);
  end

  // state and registers
  cbs_state_e           state_q, state_d;
  logic [ORDER_W-1:0]   order_q;
  logic [NW-1:0]        n_q, j_q, k_q;
  logic signed [SW-1:0] u_q;
  logic [LW-1:0]        lv_q [L];
  logic [AW-1:0]        acc_q;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_val_q;

  // control from the output decoder
  logic          in_ready;
  logic          start;
  logic          step;
  logic          lv_we;
  logic          shift2;
  logic [IW-1:0] wpos;
  logic [LW-1:0] wdata;
  logic          acc_ld;
  logic          acc_add;
  logic          out_ld;

  // effective order of the item being taken
  logic [NW-1:0] n_new;
  assign n_new = (32'(order_q) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_q);

  logic in_fire;
  assign in_fire = pos_i.valid && in_ready;

  // position of the current entry and its support
  logic signed [SW-1:0] jo_s, kk_s, x_s, d_s, ad_s, tent_s, rem_s;
  logic [NW-1:0]        top;
  logic                 last, last_level, in_sup, tent_sup;

  assign jo_s     = $signed(SW'(j_q) << FRAC_BITS);
  assign kk_s     = $signed(SW'(k_q) << FRAC_BITS);
  assign x_s      = u_q - jo_s;
  assign rem_s    = kk_s - x_s;
  assign d_s      = x_s - ONE_S;
  assign ad_s     = d_s[SW-1] ? -d_s : d_s;
  assign tent_s   = ONE_S - ad_s;
  assign top      = n_q - k_q;
  assign last     = (j_q == top);
  assign last_level = last && (k_q == n_q);
  assign in_sup   = !x_s[SW-1] && (x_s <= kk_s);
  assign tent_sup = !x_s[SW-1] && (x_s <= TENT_S);

  // shared multiplier, operands picked by the sequencer state
  logic [KW-1:0] mul_a;
  logic [RW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [IW-1:0] dsel;

  assign dsel = IW'(k_q - NW'(1));

  always_comb begin
    unique case (state_q)
      S_MUL_HI: begin
        mul_a = rem_s[KW-1:0];
        mul_b = RW'(lv_q[1]);
      end
      S_DIV: begin
        mul_a = acc_q[FRAC_BITS +: KW];
        mul_b = recip_w[dsel];
      end
      default: begin
        mul_a = x_s[KW-1:0];
        mul_b = RW'(lv_q[0]);
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (n_new < NW'(TENT_ORDER)) ? S_FINISH : S_TENT;
        end
      end
      S_TENT: begin
        if (last) begin
          state_d = (k_q == n_q) ? S_FINISH : S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        if (in_sup) begin
          state_d = S_MUL_HI;
        end else if (last_level) begin
          state_d = S_FINISH;
        end
      end
      S_MUL_HI: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        state_d = last_level ? S_FINISH : S_MUL_LO;
      end
      S_FINISH: begin
        if (!out_valid_q || val_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    start    = 1'b0;
    step     = 1'b0;
    lv_we    = 1'b0;
    shift2   = 1'b0;
    wpos     = IW'(top);
    wdata    = '0;
    acc_ld   = 1'b0;
    acc_add  = 1'b0;
    out_ld   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        start    = in_fire;
        // orders below two leave a zero in the result slot
        lv_we    = in_fire && (n_new < NW'(TENT_ORDER));
        wpos     = '0;
      end
      S_TENT: begin
        step  = 1'b1;
        lv_we = 1'b1;
        wdata = tent_sup ? LW'(tent_s) : '0;
      end
      S_MUL_LO: begin
        if (in_sup) begin
          acc_ld = 1'b1;
        end else begin
          step   = 1'b1;
          lv_we  = 1'b1;
          shift2 = last;
          wpos   = last ? IW'(top) : IW'(top + NW'(1));
        end
      end
      S_MUL_HI: begin
        acc_add = 1'b1;
      end
      S_DIV: begin
        step   = 1'b1;
        lv_we  = 1'b1;
        shift2 = last;
        wpos   = last ? IW'(top) : IW'(top + NW'(1));
        wdata  = prod[RW +: LW];
      end
      S_FINISH: begin
        out_ld = !out_valid_q || val_o.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // level slots move down one per entry; the last entry of a level above the tent drops the spent value too
  logic [LW-1:0] sh1_w [L];
  logic [LW-1:0] sh2_w [L];

  for (genvar i = 0; i < L; i++) begin : g_shift
    if (i + 1 < L) begin : g_s1
      assign sh1_w[i] = lv_q[i+1];
    end else begin : g_s1_end
      assign sh1_w[i] = '0;
    end
    if (i + 2 < L) begin : g_s2
      assign sh2_w[i] = lv_q[i+2];
    end else begin : g_s2_end
      assign sh2_w[i] = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      order_q     <= ORDER_RST;
      n_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (start) begin
        n_q <= n_new;
        j_q <= '0;
        k_q <= NW'(TENT_ORDER);
      end else if (step) begin
        if (last) begin
          j_q <= '0;
          k_q <= k_q + NW'(1);
        end else begin
          j_q <= j_q + NW'(1);
        end
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (val_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      u_q <= {{(SW - POS_W){pos_i.position[POS_W-1]}}, pos_i.position};
    end
    if (lv_we) begin
      for (int i = 0; i < L; i++) begin
        if (IW'(i) == wpos) begin
          lv_q[i] <= wdata;
        end else begin
          lv_q[i] <= shift2 ? sh2_w[i] : sh1_w[i];
        end
      end
    end
    if (acc_ld) begin
      acc_q <= AW'(prod);
    end else if (acc_add) begin
      acc_q <= acc_q + AW'(prod);
    end
    if (out_ld) begin
      out_val_q <= OUT_W'(lv_q[0]);
    end
  end

  assign pos_i.ready        = in_ready;
  assign val_o.valid        = out_valid_q;
  assign val_o.spline_value = out_val_q;

  // checks on the sequencer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_i.valid && pos_i.ready) |=> (state_q != S_IDLE))
    else $error("sequencer idle right after taking a position");

  a_level_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TENT || state_q == S_MUL_LO || state_q == S_MUL_HI || state_q == S_DIV)
    |-> (k_q <= n_q && j_q <= n_q - k_q))
    else $error("level or entry counter beyond the triangle");

  a_tent_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TENT) |-> (k_q == NW'(TENT_ORDER)))
    else $error("tent level entered at a later level");

  a_low_order_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && n_q < NW'(TENT_ORDER)) |-> (lv_q[0] == '0))
    else $error("order below two does not give zero");

endmodule

>>> verif/tb.sv
// testbench for the cardinal b-spline evaluator: random positions and orders, self-checking
module tb;
  import cbs_pkg::*;

  localparam int unsigned TB_MAX_ORDER   = 8;
  localparam int unsigned TB_FRAC_BITS   = 16;
  localparam longint      ONE            = longint'(1) << TB_FRAC_BITS;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned PHASE_ITEMS    = 112;
  localparam int unsigned NUM_PHASES     = 12;
  localparam int unsigned HOLD_CYCLES    = 400;
  // give the final drain a comfortable margin beyond the worst item at order 8
  localparam int unsigned DRAIN_CYCLES   = 150;
  // longest legal quiet stretch is the receiver hold plus one item plus gaps
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 40;

  // keeps expected spline values in transfer order and compares results with them
  class spline_scoreboard;
    logic [OUT_W-1:0] expected_values[$];
    int               mismatches;

    // cox-de boor triangle: tents at level 2, then levels 3 .. n updated in place
    function logic [OUT_W-1:0] spline_of(logic signed [POS_W-1:0] pos,
                                         logic [ORDER_W-1:0] order);
      longint          u, x, kk, d;
      longint unsigned num;
      longint unsigned level [0:TB_MAX_ORDER];
      int              n;
      n = int'(order);
      if (n > TB_MAX_ORDER) n = TB_MAX_ORDER;
      if (n < TENT_ORDER) return '0;
      u = longint'(pos);
      for (int j = 0; j <= n - TENT_ORDER; j++) begin
        x = u - j * ONE;
        if (x < 0 || x > TENT_ORDER * ONE) begin
          level[j] = 0;
        end else begin
          d = x - ONE;
          if (d < 0) d = -d;
          level[j] = longint'(ONE - d);
        end
      end
      for (int k = TENT_ORDER + 1; k <= n; k++) begin
        for (int j = 0; j <= n - k; j++) begin
          x  = u - j * ONE;
          kk = k * ONE;
          if (x < 0 || x > kk) begin
            level[j] = 0;
          end else begin
            num = longint'(x) * level[j] + longint'(kk - x) * level[j + 1];
            level[j] = (num / (k - 1)) >> TB_FRAC_BITS;
          end
        end
      end
      return level[0][OUT_W-1:0];
    endfunction

    function void note_position(logic signed [POS_W-1:0] pos, logic [ORDER_W-1:0] order);
      expected_values.push_back(spline_of(pos, order));
    endfunction

    function void check_value(logic [OUT_W-1:0] actual);
      logic [OUT_W-1:0] wanted;
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("spline_value: no transfer expected, actual %0d", actual);
        return;
      end
      wanted = expected_values.pop_front();
      if (actual !== wanted) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("spline_value: expected %0d, actual %0d", wanted, actual);
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction

    function bit clean();
      return mismatches == 0 && expected_values.size() == 0;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [ORDER_W-1:0] cfg_wdata_i;

  cbs_pos_if pos_if ();
  cbs_val_if val_if ();

  cardinal_bspline_eval u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_i       (pos_if),
    .val_o       (val_if)
  );

  always #2 clk_i = ~clk_i;

  spline_scoreboard   spline_sb = new;
  // order the block holds, mirrored here for the prediction
  logic [ORDER_W-1:0] order_q = ORDER_RST;
  // idle ranges per phase; zero gives back-to-back traffic
  int                 sender_gap_max = 6;
  int                 sink_gap_max   = 6;
  // set by the stimulus, cleared by the receiver once it has held off
  bit                 hold_request   = 1'b0;
  int                 idle_cycles;

  // clamp to the supported range and keep the tent order as the floor for sizing positions
  function automatic int support_of(logic [ORDER_W-1:0] order);
    int n;
    n = int'(order);
    if (n > TB_MAX_ORDER) n = TB_MAX_ORDER;
    if (n < TENT_ORDER) n = TENT_ORDER;
    return n;
  endfunction

  // mostly inside the support, some on or beside a knot, some anywhere in the field
  function automatic logic signed [POS_W-1:0] random_position(int n);
    int          pick;
    int          lo;
    int          hi;
    logic [31:0] bits;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      bits = $urandom();
      return bits[POS_W-1:0];
    end else if (pick < 20) begin
      lo = $urandom_range(0, n) * int'(ONE) + $urandom_range(0, 2) - 1;
      return lo[POS_W-1:0];
    end
    lo = -4096;
    hi = n * int'(ONE) + 4096;
    lo = lo + int'($urandom_range(0, hi - lo));
    return lo[POS_W-1:0];
  endfunction

  // offer one position, idle first if the draw says so, and note it once transferred
  task automatic send_position(input logic signed [POS_W-1:0] pos);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      pos_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pos_if.valid    <= 1'b1;
    pos_if.position <= pos;
    @(posedge clk_i);
    while (!pos_if.ready) @(posedge clk_i);
    spline_sb.note_position(pos, order_q);
  endtask

  // stop offering and let every outstanding value come back before the order changes
  task automatic drain_results();
    pos_if.valid <= 1'b0;
    while (spline_sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    order_q      = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // field extremes, the lower support edge, one and a half, the upper support edge and just past it
  task automatic send_directed();
    int n;
    n = support_of(order_q);
    send_position(21'sh100000);
    send_position(21'sh0fffff);
    send_position('0);
    send_position(POS_W'(3 * int'(ONE) / 2));
    send_position(POS_W'(n * int'(ONE)));
    send_position(POS_W'(n * int'(ONE) + 1));
  endtask

  // result side: random gaps, one long hold-off on request
  initial begin
    int gap;
    val_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        val_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      gap = $urandom_range(0, sink_gap_max);
      if (gap > 0) begin
        val_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      val_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!val_if.valid) @(posedge clk_i);
      spline_sb.check_value(val_if.spline_value);
    end
  end

  // watchdog: any stretch without a transfer on either channel that runs too long is a hang
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((pos_if.valid && pos_if.ready) || (val_if.valid && val_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ORDER_W-1:0] fixed_orders [0:9];
    logic [ORDER_W-1:0] order;
    int                 n;

    // first phases pin down the extremes, clamping and the degenerate orders
    fixed_orders = '{4'd8, 4'd2, 4'd1, 4'd3, 4'd5, 4'd6, 4'd7, 4'd0, 4'd15, 4'd9};

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    pos_if.valid    <= 1'b0;
    pos_if.position <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: reset order first, then the lowest, the tent, and an over-range order
    send_directed();
    drain_results();
    write_order(4'd0);
    send_directed();
    drain_results();
    write_order(4'd2);
    send_directed();
    drain_results();
    write_order(4'd15);
    send_directed();
    drain_results();

    // random part: one order per phase, idle pattern rotating between phases
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 10) begin
        order = fixed_orders[phase];
      end else if ($urandom_range(0, 3) == 0) begin
        order = ORDER_W'($urandom_range(0, 15));
      end else begin
        order = ORDER_W'($urandom_range(TENT_ORDER, TB_MAX_ORDER));
      end
      write_order(order);
      sender_gap_max = (phase % 4 == 0 || phase % 4 == 2) ? 6 : 0;
      sink_gap_max   = (phase % 4 == 0 || phase % 4 == 3) ? 6 : 0;
      // back-pressure: the sink stalls while positions keep coming so the input stalls too
      if (phase == 0) hold_request = 1'b1;
      n = support_of(order);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_position(random_position(n));
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (spline_sb.clean())
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
hdl/cbs_pkg.sv
hdl/cbs_pos_if.sv
hdl/cbs_val_if.sv
hdl/cardinal_bspline_eval.sv
verif/tb.sv
